// ===== rtl/swms_pkg.sv =====
// Package: payload types and cell link types for the sliding window median block.
`default_nettype none

package swms_pkg;

  // Sample width and running sum width
  localparam int unsigned SampleW = 16;
  localparam int unsigned SumW    = 48;
  localparam int unsigned CfgW    = 7;

  // Input transaction payload
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               restart;
  } swms_in_t;

  // Output transaction payload
  typedef struct packed {
    logic               median_valid;
    logic [SampleW-1:0] median;
    logic [SumW-1:0]    median_sum;
  } swms_out_t;

  // What one cell shows its neighbors: value and where it moves on an update
  typedef struct packed {
    logic [SampleW-1:0] val;
    logic               up;    // moves to the next higher cell
    logic               down;  // moves to the next lower cell
  } swms_link_t;

  // Broadcast to all cells for one update
  typedef struct packed {
    logic               load;    // a transaction is taken this cycle
    logic               full;    // window full: the oldest entry leaves
    logic [SampleW-1:0] sample;  // incoming sample
    logic [SampleW-1:0] rm_val;  // value of the leaving entry
  } swms_bcast_t;

endpackage

`default_nettype wire

// ===== rtl/sliding_window_median_sum_top.sv =====
// Top level: running lower median over a sliding window with a saturating sum.
// A taken input transaction is sorted into the cell registers, then its result is registered
// at the output. Throughput: one transaction per cycle while the output side does not stall;
// the cell chain does the sorting, the median select and sum add feed the output register.
// Reset: window empty, sum zero, window size 1; no output pending.
`default_nettype none

module sliding_window_median_sum_top #(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [swms_pkg::CfgW-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire swms_pkg::swms_in_t    in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output swms_pkg::swms_out_t        out_data_o
);

  localparam int unsigned KW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam logic [swms_pkg::SumW:0] SumMax = {1'b0, {swms_pkg::SumW{1'b1}}};

  logic [KW-1:0] k_q, k_d, fill_q, fill_eff, fill_new;
  logic          in_acc, full, finish;
  logic          pend_q, pend_valid_q, pend_restart_q;
  logic          out_valid_q;
  swms_pkg::swms_out_t        out_q;
  logic [swms_pkg::SumW-1:0]  sum_q, sum_base;
  logic [swms_pkg::SumW:0]    sum_add;
  logic [swms_pkg::SampleW-1:0] med;
  logic [KW-1:0] med_idx;
  logic [31:0]   cfg_clamp;
  logic [IW-1:0] kill_age;

  swms_pkg::swms_bcast_t bc;
  swms_pkg::swms_link_t  link  [WINDOW_MAX];
  logic [IW-1:0]         age   [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] rm;

  // Handshake: a new transaction may enter while the previous one finishes
  assign finish      = pend_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = pend_q && !finish;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Window size clamp to 1..WINDOW_MAX
  always_comb begin
    cfg_clamp = 32'(cfg_wdata_i);
    if (cfg_clamp == 32'd0) begin
      cfg_clamp = 32'd1;
    end else if (cfg_clamp > WINDOW_MAX) begin
      cfg_clamp = WINDOW_MAX;
    end
    k_d = cfg_clamp[KW-1:0];
  end

  // Fill bookkeeping for the transaction being taken
  always_comb begin
    fill_eff = in_data_i.restart ? '0 : fill_q;
    full     = fill_eff == k_q;
    fill_new = full ? k_q : fill_eff + KW'(1);
    kill_age = IW'(k_q - KW'(1));
    bc.load   = in_acc;
    bc.full   = full;
    bc.sample = in_data_i.sample;
  end

  // Value of the leaving entry (at most one cell flags it)
  always_comb begin
    bc.rm_val = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      bc.rm_val = bc.rm_val | (rm[i] ? link[i].val : '0);
    end
  end

  // Chain of cells, each linked to its two neighbors
  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    swms_pkg::swms_link_t prev_l, next_l;
    logic [IW-1:0]        prev_a, next_a;
    if (g == 0) begin : g_lo
      assign prev_l = '0;
      assign prev_a = '0;
    end else begin : g_lo_n
      assign prev_l = link[g-1];
      assign prev_a = age[g-1];
    end
    if (g == WINDOW_MAX - 1) begin : g_hi
      assign next_l = '0;
      assign next_a = '0;
    end else begin : g_hi_n
      assign next_l = link[g+1];
      assign next_a = age[g+1];
    end
    swms_cell #(
      .IDX(g),
      .KW (KW),
      .AW (IW)
    ) u_cell (
      .clk_i      (clk_i),
      .bc_i       (bc),
      .kill_age_i (kill_age),
      .fill_i     (fill_eff),
      .fill_new_i (fill_new),
      .prev_i     (prev_l),
      .prev_age_i (prev_a),
      .next_i     (next_l),
      .next_age_i (next_a),
      .link_o     (link[g]),
      .age_o      (age[g]),
      .rm_o       (rm[g])
    );
  end

  // Lower median select and saturating sum
  always_comb begin
    med_idx  = (k_q - KW'(1)) >> 1;
    med      = pend_valid_q ? link[med_idx[IW-1:0]].val : '0;
    sum_base = pend_restart_q ? '0 : sum_q;
    sum_add  = {1'b0, sum_base} + (swms_pkg::SumW + 1)'(med);
    if (sum_add > SumMax) begin
      sum_add = SumMax;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= KW'(1);
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        k_q    <= k_d;
        fill_q <= '0;
      end else if (in_acc) begin
        fill_q <= fill_new;
      end
      if (in_acc) begin
        pend_q <= 1'b1;
      end else if (finish) begin
        pend_q <= 1'b0;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
        sum_q       <= sum_add[swms_pkg::SumW-1:0];
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pending transaction flags and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_valid_q   <= fill_new == k_q;
      pend_restart_q <= in_data_i.restart;
    end
    if (finish) begin
      out_q.median_valid <= pend_valid_q;
      out_q.median       <= med;
      out_q.median_sum   <= sum_add[swms_pkg::SumW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swms_cell.sv =====
// One cell of the sorted window chain: holds one entry and its age.
`default_nettype none

module swms_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned KW  = 7,
  parameter int unsigned AW  = 6
) (
  input  wire logic                 clk_i,
  input  wire swms_pkg::swms_bcast_t bc_i,
  input  wire logic [AW-1:0]        kill_age_i,
  input  wire logic [KW-1:0]        fill_i,
  input  wire logic [KW-1:0]        fill_new_i,
  input  wire swms_pkg::swms_link_t prev_i,
  input  wire logic [AW-1:0]        prev_age_i,
  input  wire swms_pkg::swms_link_t next_i,
  input  wire logic [AW-1:0]        next_age_i,
  output swms_pkg::swms_link_t      link_o,
  output logic [AW-1:0]             age_o,
  output logic                      rm_o
);

  logic [swms_pkg::SampleW-1:0] val_q, val_d;
  logic [AW-1:0]                age_q, age_d;
  logic                         valid, retain, gt_rm, lt_s, stay, live_new;

  // Order key is (value, age): the leaving entry splits cells into below and above
  always_comb begin
    valid  = KW'(IDX) < fill_i;
    rm_o   = bc_i.full && valid && (age_q == kill_age_i);
    retain = valid && !rm_o;
    gt_rm  = bc_i.full && ((val_q > bc_i.rm_val) ||
                           ((val_q == bc_i.rm_val) && (age_q > kill_age_i)));
    lt_s   = val_q < bc_i.sample;
    stay   = retain && (gt_rm ^ lt_s);
    link_o.val  = val_q;
    link_o.up   = retain && !gt_rm && !lt_s;
    link_o.down = retain && gt_rm && lt_s;
    age_o       = age_q;
    live_new    = KW'(IDX) < fill_new_i;
  end

  // Pick the entry that lands here: upper neighbor, lower neighbor, own, or the new sample
  always_comb begin
    val_d = bc_i.sample;
    age_d = '0;
    if (next_i.down) begin
      val_d = next_i.val;
      age_d = next_age_i + AW'(1);
    end else if (prev_i.up) begin
      val_d = prev_i.val;
      age_d = prev_age_i + AW'(1);
    end else if (stay) begin
      val_d = val_q;
      age_d = age_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (bc_i.load && live_new) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

endmodule

`default_nettype wire

// ===== sim/sliding_window_median_sum_top_tb.sv =====
// Testbench for the sliding window median block: directed and random stimulus, scoreboard check.
`timescale 1ns / 1ps

module sliding_window_median_sum_top_tb;

  localparam int unsigned WinMax = 64;
  localparam logic [swms_pkg::SumW-1:0] SumTop = '1;

  // Median predictor and queue of expected results
  class median_scoreboard;
    logic [swms_pkg::SampleW-1:0] arrival[WinMax];
    logic [swms_pkg::SampleW-1:0] ordered[WinMax];
    int unsigned                  win_len;
    int unsigned                  fill;
    int unsigned                  oldest;
    logic [swms_pkg::SumW-1:0]    sum_acc;
    swms_pkg::swms_out_t          expected_q[$];
    int                           errors;

    function new();
      win_len = 1;
      fill    = 0;
      oldest  = 0;
      sum_acc = '0;
      errors  = 0;
    endfunction

    task flag_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Register write: clamp into 1..WinMax and empty the window, sum is kept
    function void set_window(input logic [swms_pkg::CfgW-1:0] v);
      if (v < 1) begin
        win_len = 1;
      end else if (v > WinMax) begin
        win_len = WinMax;
      end else begin
        win_len = v;
      end
      fill   = 0;
      oldest = 0;
    endfunction

    // Insert into the ascending list that currently holds len entries
    function void place_sorted(input logic [swms_pkg::SampleW-1:0] v,
                               input int unsigned len);
      int unsigned i;
      i = len;
      while (i > 0 && ordered[i-1] > v) begin
        ordered[i] = ordered[i-1];
        i--;
      end
      ordered[i] = v;
    endfunction

    // Accepted input transaction: advance the window and queue the expected result
    function void note_input(input swms_pkg::swms_in_t t);
      logic [swms_pkg::SampleW-1:0] s;
      logic [swms_pkg::SampleW-1:0] med;
      logic [swms_pkg::SumW:0]      nxt;
      int unsigned                  pos;
      int unsigned                  r;
      int unsigned                  i;
      swms_pkg::swms_out_t          exp_r;
      s = t.sample;
      if (t.restart) begin
        fill    = 0;
        oldest  = 0;
        sum_acc = '0;
      end
      if (fill < win_len) begin
        arrival[fill] = s;
        place_sorted(s, fill);
        fill++;
        oldest = 0;
      end else begin
        pos = (oldest >= win_len) ? 0 : oldest;
        // drop the leaving sample from the ordered list (first equal entry)
        r = 0;
        while (r + 1 < win_len && ordered[r] != arrival[pos]) r++;
        for (i = r; i + 1 < win_len; i++) ordered[i] = ordered[i+1];
        place_sorted(s, win_len - 1);
        arrival[pos] = s;
        pos++;
        oldest = (pos >= win_len) ? 0 : pos;
      end
      exp_r = '0;
      if (fill == win_len) begin
        med = ordered[(win_len + 1) / 2 - 1];
        exp_r.median_valid = 1'b1;
        exp_r.median       = med;
        nxt = {1'b0, sum_acc} + (swms_pkg::SumW + 1)'(med);
        sum_acc = (nxt > SumTop) ? SumTop : nxt[swms_pkg::SumW-1:0];
      end
      exp_r.median_sum = sum_acc;
      expected_q = {expected_q, exp_r};
    endfunction

    // Accepted output transaction: compare with the oldest expectation
    task check_result(input swms_pkg::swms_out_t got);
      swms_pkg::swms_out_t want;
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: %p", got));
      end else begin
        want = expected_q.pop_front();
        if (got.median_valid !== want.median_valid) begin
          flag_mismatch($sformatf("median_valid got %b want %b",
                                  got.median_valid, want.median_valid));
        end
        if (got.median !== want.median) begin
          flag_mismatch($sformatf("median got %h want %h", got.median, want.median));
        end
        if (got.median_sum !== want.median_sum) begin
          flag_mismatch($sformatf("median_sum got %h want %h",
                                  got.median_sum, want.median_sum));
        end
      end
    endtask
  endclass

  // Clock, reset and block inputs, all known from time zero
  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [swms_pkg::CfgW-1:0] cfg_wdata = '0;
  logic                      in_valid  = 1'b0;
  swms_pkg::swms_in_t        in_data   = '0;
  logic                      out_stall = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  swms_pkg::swms_out_t       out_data;

  bit               idle_on = 1'b0;
  median_scoreboard sb      = new();

  always #6 clk = ~clk;

  sliding_window_median_sum_top #(
    .WINDOW_MAX(WinMax)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // Handshake monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) begin
        sb.note_input(in_data);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        sb.check_result(out_data);
      end
    end
  end

  // Output side stall bursts
  initial begin : stall_gen
    int n;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one input transaction, with an optional idle burst ahead of it
  task automatic send_item(input logic [swms_pkg::SampleW-1:0] s, input logic rs);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.sample  <= s;
    in_data.restart <= rs;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Stop sending and wait until every expected result has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_window(input logic [swms_pkg::CfgW-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_window(v);
  endtask

  // Sample mix: full range, a few small values (many duplicates), or the extremes and the midpoint
  function automatic logic [swms_pkg::SampleW-1:0] pick_sample();
    int unsigned m;
    m = $urandom_range(0, 9);
    if (m < 6) return swms_pkg::SampleW'($urandom());
    if (m < 8) return swms_pkg::SampleW'($urandom_range(0, 7));
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return 16'h8000;
    endcase
  endfunction

  // Fail-safe on a hang
  initial begin
    #10_000_000;
    $display("** sliding_window_median_sum_top: FAILED **");
    $finish;
  end

  // Main sequence
  initial begin : main_seq
    logic [swms_pkg::CfgW-1:0] plan[8];
    logic [swms_pkg::CfgW-1:0] wv;
    plan = '{7'd64, 7'd127, 7'd2, 7'd65, 7'd0, 7'd63, 7'd1, 7'd5};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: window of one after reset on the extremes, then a restart
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'hAAAA, 1'b1);
    // zero is taken as a window of one
    write_window(7'd0);
    send_item(16'h5555, 1'b0);
    send_item(16'hFFFF, 1'b0);
    // window of four: lower median, duplicates leaving, restart part way in
    write_window(7'd4);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h5555, 1'b0);
    send_item(16'hAAAA, 1'b0);
    send_item(16'h0007, 1'b0);
    send_item(16'h0007, 1'b0);
    send_item(16'h0007, 1'b0);
    send_item(16'h0007, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h1234, 1'b1);
    send_item(16'h0001, 1'b0);
    send_item(16'h0002, 1'b0);
    send_item(16'h0003, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h8000, 1'b0);

    // Random phases over several window sizes; no idling in the last two
    for (int ph = 0; ph < 10; ph++) begin
      wv = (ph < 8) ? plan[ph] : swms_pkg::CfgW'($urandom_range(0, 127));
      write_window(wv);
      idle_on = (ph < 8) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 170; n++) begin
        send_item(pick_sample(), $urandom_range(0, 79) == 0);
      end
    end

    idle_on = 1'b0;
    settle();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.flag_mismatch($sformatf("%0d results never came", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("** sliding_window_median_sum_top: PASSED **");
    end else begin
      $display("** sliding_window_median_sum_top: FAILED **");
    end
    $finish;
  end

endmodule
